### src/fsp_pkg.sv
// ----------------------------------------------------------------------------
// fsp_pkg
// Shared types and constants for the format spec field parser.
// ----------------------------------------------------------------------------
package fsp_pkg;

    // default width of the width and precision accumulators
    localparam int VALUE_BITS_DEF = 31;

    // width of the width and precision result fields
    localparam int FIELD_W = 31;

    typedef struct packed {
        logic [7:0] ch;
        logic       begin_req;
    } t_in_item;

    typedef struct packed {
        logic [4:0]         flag_mask;
        logic [FIELD_W-1:0] width;
        logic               width_from_arg;
        logic               precision_given;
        logic [FIELD_W-1:0] precision;
        logic               precision_from_arg;
        logic [2:0]         length_mod;
        logic [7:0]         conv_char;
        logic               has_conv;
    } t_out_item;

endpackage

### src/fsp_dec_acc.sv
// ----------------------------------------------------------------------------
// fsp_dec_acc
// Saturating decimal accumulator: acc * 10 + digit, clamped to all ones.
// ----------------------------------------------------------------------------
module fsp_dec_acc #(
    parameter int VALUE_BITS = fsp_pkg::VALUE_BITS_DEF
) (
    input  logic [VALUE_BITS-1:0] i_acc,
    input  logic [3:0]            i_digit,
    output logic [VALUE_BITS-1:0] o_acc
);

    localparam int SW = VALUE_BITS + 4;

    logic [SW-1:0] prod;
    logic [SW-1:0] sum;

    // acc * 10 as (acc << 3) + (acc << 1); fits in four extra bits
    assign prod = {1'b0, i_acc, 3'b000} + {3'b000, i_acc, 1'b0};
    assign sum  = prod + {{(SW-4){1'b0}}, i_digit};

    assign o_acc = (sum[SW-1:VALUE_BITS] != 4'd0) ? {VALUE_BITS{1'b1}}
                                                  : sum[VALUE_BITS-1:0];

endmodule

### src/fsp_core.sv
// ----------------------------------------------------------------------------
// fsp_core
// Spec state and per-character decode; flags a result on the ending character.
// ----------------------------------------------------------------------------
module fsp_core #(
    parameter int VALUE_BITS = fsp_pkg::VALUE_BITS_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_go,
    input  fsp_pkg::t_in_item  i_item,
    output logic               o_res_valid,
    output fsp_pkg::t_out_item o_res
);

    typedef enum logic [7:0] {
        PH_FLAGS = 8'b0000_0001,
        PH_WIDTH = 8'b0000_0010,
        PH_WSKIP = 8'b0000_0100,
        PH_DOT   = 8'b0000_1000,
        PH_PREC  = 8'b0001_0000,
        PH_PSKIP = 8'b0010_0000,
        PH_LEN2  = 8'b0100_0000,
        PH_LSKIP = 8'b1000_0000
    } t_phase;

    localparam logic [2:0] LEN_NONE = 3'd0;
    localparam logic [2:0] LEN_HH   = 3'd1;
    localparam logic [2:0] LEN_H    = 3'd2;
    localparam logic [2:0] LEN_L    = 3'd3;
    localparam logic [2:0] LEN_LL   = 3'd4;
    localparam logic [2:0] LEN_J    = 3'd5;
    localparam logic [2:0] LEN_Z    = 3'd6;

    localparam logic [7:0] CH_HASH  = 8'h23;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;
    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_PLUS  = 8'h2B;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_STAR  = 8'h2A;
    localparam logic [7:0] CH_DOT   = 8'h2E;
    localparam logic [7:0] CH_H     = 8'h68;
    localparam logic [7:0] CH_L     = 8'h6C;
    localparam logic [7:0] CH_J     = 8'h6A;
    localparam logic [7:0] CH_Z     = 8'h7A;

    localparam int FB_HASH  = 0;
    localparam int FB_ZERO  = 1;
    localparam int FB_MINUS = 2;
    localparam int FB_PLUS  = 3;
    localparam int FB_SPACE = 4;

    t_phase                r_phase,      n_phase,      cur_phase;
    logic [4:0]            r_flags,      n_flags,      cur_flags;
    logic [VALUE_BITS-1:0] r_width_acc,  n_width_acc,  cur_width_acc;
    logic                  r_width_star, n_width_star, cur_width_star;
    logic [VALUE_BITS-1:0] r_prec_acc,   n_prec_acc,   cur_prec_acc;
    logic                  r_prec_seen,  n_prec_seen,  cur_prec_seen;
    logic                  r_prec_star,  n_prec_star,  cur_prec_star;
    logic [2:0]            r_len,        n_len,        cur_len;

    logic [7:0]            c;
    logic                  c_digit;
    logic                  c_len;
    logic                  fin;
    logic                  go_after;
    logic                  go_len;
    logic [VALUE_BITS-1:0] width_step;
    logic [VALUE_BITS-1:0] prec_step;

    assign c       = i_item.ch;
    assign c_digit = (c >= CH_ZERO) && (c <= CH_NINE);
    assign c_len   = (c == CH_H) || (c == CH_L) || (c == CH_J) || (c == CH_Z);

    // a start request works on a freshly cleared spec
    always_comb begin
        if (i_item.begin_req) begin
            cur_phase      = PH_FLAGS;
            cur_flags      = '0;
            cur_width_acc  = '0;
            cur_width_star = 1'b0;
            cur_prec_acc   = '0;
            cur_prec_seen  = 1'b0;
            cur_prec_star  = 1'b0;
            cur_len        = LEN_NONE;
        end else begin
            cur_phase      = r_phase;
            cur_flags      = r_flags;
            cur_width_acc  = r_width_acc;
            cur_width_star = r_width_star;
            cur_prec_acc   = r_prec_acc;
            cur_prec_seen  = r_prec_seen;
            cur_prec_star  = r_prec_star;
            cur_len        = r_len;
        end
    end

    fsp_dec_acc #(.VALUE_BITS(VALUE_BITS)) u_width_acc (
        .i_acc   (cur_width_acc),
        .i_digit (c[3:0]),
        .o_acc   (width_step)
    );

    fsp_dec_acc #(.VALUE_BITS(VALUE_BITS)) u_prec_acc (
        .i_acc   (cur_prec_acc),
        .i_digit (c[3:0]),
        .o_acc   (prec_step)
    );

    always_comb begin
        n_phase      = cur_phase;
        n_flags      = cur_flags;
        n_width_acc  = cur_width_acc;
        n_width_star = cur_width_star;
        n_prec_acc   = cur_prec_acc;
        n_prec_seen  = cur_prec_seen;
        n_prec_star  = cur_prec_star;
        n_len        = cur_len;
        go_after     = 1'b0;
        go_len       = 1'b0;
        fin          = 1'b0;

        unique case (cur_phase)
            PH_FLAGS: begin
                if (c == CH_HASH) begin
                    n_flags[FB_HASH] = 1'b1;
                end else if (c == CH_ZERO) begin
                    n_flags[FB_ZERO] = 1'b1;
                end else if (c == CH_MINUS) begin
                    n_flags[FB_MINUS] = 1'b1;
                end else if (c == CH_PLUS) begin
                    n_flags[FB_PLUS] = 1'b1;
                end else if (c == CH_SPACE) begin
                    n_flags[FB_SPACE] = 1'b1;
                end else if (c == CH_STAR) begin
                    n_width_star = 1'b1;
                    n_phase      = PH_WSKIP;
                end else if (c_digit) begin
                    n_width_acc = width_step;
                    n_phase     = PH_WIDTH;
                end else begin
                    go_after = 1'b1;
                end
            end
            PH_WIDTH: begin
                if (c_digit) begin
                    n_width_acc = width_step;
                end else begin
                    go_after = 1'b1;
                end
            end
            PH_WSKIP: begin
                go_after = !c_digit;
            end
            PH_DOT: begin
                if (c == CH_STAR) begin
                    n_prec_star = 1'b1;
                    n_phase     = PH_PSKIP;
                end else if (c_digit) begin
                    n_prec_acc = prec_step;
                    n_phase    = PH_PREC;
                end else begin
                    go_len = 1'b1;
                end
            end
            PH_PREC: begin
                if (c_digit) begin
                    n_prec_acc = prec_step;
                end else begin
                    go_len = 1'b1;
                end
            end
            PH_PSKIP: begin
                go_len = !c_digit;
            end
            PH_LEN2: begin
                if (c == CH_L && cur_len == LEN_L) begin
                    n_len = LEN_LL;
                end else if (c == CH_H && cur_len == LEN_H) begin
                    n_len = LEN_HH;
                end
                if (c_len) begin
                    n_phase = PH_LSKIP;
                end else begin
                    fin = 1'b1;
                end
            end
            PH_LSKIP: begin
                fin = !c_len;
            end
            default: begin
                fin = !c_len;
            end
        endcase

        if (go_after) begin
            if (c == CH_DOT) begin
                n_prec_seen = 1'b1;
                n_phase     = PH_DOT;
            end else begin
                go_len = 1'b1;
            end
        end

        if (go_len) begin
            priority if (c == CH_Z) begin
                n_len   = LEN_Z;
                n_phase = PH_LSKIP;
            end else if (c == CH_J) begin
                n_len   = LEN_J;
                n_phase = PH_LSKIP;
            end else if (c == CH_L) begin
                n_len   = LEN_L;
                n_phase = PH_LEN2;
            end else if (c == CH_H) begin
                n_len   = LEN_H;
                n_phase = PH_LEN2;
            end else begin
                fin = 1'b1;
            end
        end
    end

    assign o_res_valid              = fin;
    assign o_res.flag_mask          = n_flags;
    assign o_res.width              = fsp_pkg::FIELD_W'(n_width_acc);
    assign o_res.width_from_arg     = n_width_star;
    assign o_res.precision_given    = n_prec_seen;
    assign o_res.precision          = fsp_pkg::FIELD_W'(n_prec_acc);
    assign o_res.precision_from_arg = n_prec_star;
    assign o_res.length_mod         = n_len;
    assign o_res.conv_char          = c;
    assign o_res.has_conv           = (c != 8'd0);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || (i_go && fin)) begin
            r_phase      <= PH_FLAGS;
            r_flags      <= '0;
            r_width_acc  <= '0;
            r_width_star <= 1'b0;
            r_prec_acc   <= '0;
            r_prec_seen  <= 1'b0;
            r_prec_star  <= 1'b0;
            r_len        <= LEN_NONE;
        end else if (i_go) begin
            r_phase      <= n_phase;
            r_flags      <= n_flags;
            r_width_acc  <= n_width_acc;
            r_width_star <= n_width_star;
            r_prec_acc   <= n_prec_acc;
            r_prec_seen  <= n_prec_seen;
            r_prec_star  <= n_prec_star;
            r_len        <= n_len;
        end
    end

`ifndef SYNTHESIS
    // a finished spec leaves the state cleared
    a_fin_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_go && fin) |=> (r_phase == PH_FLAGS && r_len == LEN_NONE))
        else $error("state not cleared after a result");

    // in the flags phase nothing beyond flags has been collected
    a_flags_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase == PH_FLAGS) |-> (r_width_acc == '0 && r_prec_acc == '0 &&
                                   !r_prec_seen && !r_width_star && r_len == LEN_NONE))
        else $error("flags phase with collected fields");

    // skipping digits after a star never accumulates a width
    a_wskip_star: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase == PH_WSKIP) |-> (r_width_star && r_width_acc == '0))
        else $error("width skip phase without star");
`endif

endmodule

### src/format_spec_field_parser.sv
// ----------------------------------------------------------------------------
// format_spec_field_parser
// Decodes one printf style conversion spec from a stream of characters.
// ----------------------------------------------------------------------------
//  channel | direction | payload              | handshake
//  --------+-----------+----------------------+--------------------------------
//  in      | input     | t_in_item (ch, begin)| i_in_valid / o_in_stall
//  out     | output    | t_out_item (9 fields)| o_out_valid / i_out_stall
//
// One character per cycle unless a held result stalls decode; a character is
// taken into the input register and its result, if any, goes to the result
// register; the rate is set by the combinational decode between the two.
// Synchronous active-low reset clears the spec state and both valid flags.
// A held result stalls decode; the input register still takes one more item if empty.
// ----------------------------------------------------------------------------
module format_spec_field_parser #(
    parameter int VALUE_BITS = fsp_pkg::VALUE_BITS_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    input  fsp_pkg::t_in_item  i_in_item,
    output logic               o_in_stall,
    output logic               o_out_valid,
    output fsp_pkg::t_out_item o_out_item,
    input  logic               i_out_stall
);

    logic               r_in_valid;
    fsp_pkg::t_in_item  r_in_item;
    logic               r_out_valid;
    fsp_pkg::t_out_item r_out_item;

    logic               go;
    logic               res_valid;
    fsp_pkg::t_out_item res;

    // decode only when the result slot is free or being emptied
    assign go         = r_in_valid && (!r_out_valid || !i_out_stall);
    assign o_in_stall = r_in_valid && !go;

    fsp_core #(.VALUE_BITS(VALUE_BITS)) u_core (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_go        (go),
        .i_item      (r_in_item),
        .o_res_valid (res_valid),
        .o_res       (res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_in_valid && !o_in_stall) begin
            r_in_valid <= 1'b1;
        end else if (go) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in_valid && !o_in_stall) begin
            r_in_item <= i_in_item;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (go && res_valid) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (go && res_valid) begin
            r_out_item <= res;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out_item;

`ifndef SYNTHESIS
    // input side stalls only when a held result blocks decode
    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |-> (r_in_valid && r_out_valid && i_out_stall))
        else $error("input stalled without a blocked result");

    // a new result appears only from a decoded item
    a_out_source: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> $past(go && res_valid))
        else $error("result without a decoded item");

    // conversion flag agrees with the ending character
    a_has_conv: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_out_item.has_conv == (o_out_item.conv_char != 8'd0)))
        else $error("has_conv does not match conv_char");
`endif

endmodule
